// ===== rtl/scope_front_panel_control_assert.svh =====
// Assertion macros shared by the front-panel control RTL.
// Included by modules that check their own logic; no other dependencies.
// Checks compile away when SYNTHESIS is defined.
`ifndef SCOPE_FRONT_PANEL_CONTROL_ASSERT_SVH
`define SCOPE_FRONT_PANEL_CONTROL_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is high.
`define SPFC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define SPFC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPFC_ASSERT(label, clk, rst, prop, msg)
`define SPFC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/spfc_pkg.sv =====
// Shared types and constants of the scope front-panel control block.
// No dependencies; imported by spfc_core and scope_front_panel_control.
`timescale 1ns / 1ps
`default_nettype none

package spfc_pkg;

  // Table and converter sizes.
  localparam int ADC_BITS           = 12;
  localparam int VOLTS_TABLE_MAX    = 16;
  localparam int TIMEBASE_TABLE_MAX = 32;

  // Largest level the converter can produce.
  localparam logic [16:0] ADC_FULL = 17'((1 << ADC_BITS) - 1);

  // Configuration port widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_POSITION_STEP     = 3'd0,
    CFG_VERTICAL_STEP     = 3'd1,
    CFG_TRIGGER_STEP      = 3'd2,
    CFG_ADC_MAX           = 3'd3,
    CFG_VOLTS_SCALE_COUNT = 3'd4,
    CFG_TIMEBASE_COUNT    = 3'd5
  } cfg_index_t;

  // Configuration register file.
  typedef struct packed {
    logic [7:0]  position_step;
    logic [7:0]  vertical_step;
    logic [11:0] trigger_step;
    logic [11:0] adc_max;
    logic [4:0]  volts_scale_count;
    logic [5:0]  timebase_count;
  } cfg_t;

  // One front-panel poll.
  typedef struct packed {
    logic              channel_switch;
    logic              axis_switch;
    logic signed [7:0] trig_turns;
    logic signed [7:0] shift_turns;
    logic signed [7:0] scale_turns;
  } item_t;

  // One result of a poll.
  typedef struct packed {
    logic               redraw;
    logic               capture_restart;
    logic               current_channel;
    logic               current_axis;
    logic [11:0]        trigger_level_out;
    logic [4:0]         timebase_out;
    logic [3:0]         volts_index_out;
    logic signed [15:0] vertical_out;
    logic signed [15:0] horizontal_out;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/spfc_core.sv =====
// Panel state registers and the single-pass update for one poll.
// Depends on spfc_pkg and scope_front_panel_control_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "scope_front_panel_control_assert.svh"

module spfc_core
  import spfc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire item_t   item,
  input  wire logic    step,
  output result_t      result
);

  localparam logic [4:0] VOLTS_MAX_C = 5'(VOLTS_TABLE_MAX);
  localparam logic [5:0] TB_MAX_C    = 6'(TIMEBASE_TABLE_MAX);

  // Panel state.
  logic               active_chan;
  logic               axis_mode;
  logic [11:0]        trigger_level;
  logic [4:0]         timebase_sel;
  logic [3:0]         volts_sel [2];
  logic signed [15:0] vertical_offset [2];
  logic signed [15:0] horizontal_offset [2];

  // Next values.
  logic [11:0]        trigger_level_next;
  logic [4:0]         timebase_sel_next;
  logic [3:0]         volts_next;
  logic signed [15:0] vertical_next;
  logic signed [15:0] horizontal_next;

  logic               ch;
  logic               axis;
  logic               chan_chg;
  logic               axis_chg;
  logic               trig_move;
  logic               shift_move;
  logic               scale_move;

  // Trigger path.
  logic [11:0]        trig_limit;
  logic signed [20:0] trig_prod;
  logic signed [21:0] trig_req;
  logic [11:0]        trig_clamped;
  logic               trig_chg;

  // Shift path, shared by both axes.
  logic [7:0]         shift_step;
  logic signed [15:0] shift_cur;
  logic signed [16:0] shift_prod;
  logic signed [17:0] shift_req;
  logic signed [15:0] shift_sat;
  logic               horiz_chg;

  // Scale path, table indices.
  logic [4:0]         vol_n;
  logic [3:0]         vol_last;
  logic signed [9:0]  vol_req;
  logic [3:0]         vol_clamped;
  logic               vol_chg;
  logic [5:0]         tb_n;
  logic [4:0]         tb_last;
  logic signed [9:0]  tb_req;
  logic [4:0]         tb_clamped;
  logic               tb_chg;

  assign ch   = item.channel_switch;
  assign axis = item.axis_switch;

  assign chan_chg   = (ch != active_chan);
  assign axis_chg   = (axis != axis_mode);
  assign trig_move  = (item.trig_turns != 8'sd0);
  assign shift_move = (item.shift_turns != 8'sd0);
  assign scale_move = (item.scale_turns != 8'sd0);

  // Trigger level: move by delta times step, clamp to the usable ADC range.
  always_comb begin
    trig_limit = ({5'b0, cfg.adc_max} > ADC_FULL) ? ADC_FULL[11:0] : cfg.adc_max;
    trig_prod  = {{13{item.trig_turns[7]}}, item.trig_turns}
               * $signed({9'b0, cfg.trigger_step});
    trig_req   = $signed({10'b0, trigger_level}) + {trig_prod[20], trig_prod};
    if (trig_req < 22'sd0) begin
      trig_clamped = 12'd0;
    end else if (trig_req > $signed({10'b0, trig_limit})) begin
      trig_clamped = trig_limit;
    end else begin
      trig_clamped = trig_req[11:0];
    end
    trig_chg           = trig_move && (trig_clamped != trigger_level);
    trigger_level_next = trig_move ? trig_clamped : trigger_level;
  end

  // Shift: one multiplier serves whichever axis is active, then saturates.
  always_comb begin
    shift_step = axis ? cfg.position_step : cfg.vertical_step;
    shift_cur  = axis ? horizontal_offset[ch] : vertical_offset[ch];
    shift_prod = {{9{item.shift_turns[7]}}, item.shift_turns} * $signed({9'b0, shift_step});
    shift_req  = {{2{shift_cur[15]}}, shift_cur} + {shift_prod[16], shift_prod};
    if (shift_req > 18'sd32767) begin
      shift_sat = 16'sh7FFF;
    end else if (shift_req < -18'sd32768) begin
      shift_sat = 16'sh8000;
    end else begin
      shift_sat = shift_req[15:0];
    end
  end

  // Volts-per-division index, clamped to the entries in use.
  always_comb begin
    vol_n = (cfg.volts_scale_count > VOLTS_MAX_C) ? VOLTS_MAX_C : cfg.volts_scale_count;
    if (vol_n == 5'd0) begin
      vol_n = 5'd1;
    end
    vol_last = 4'(vol_n - 5'd1);
    vol_req  = $signed({6'b0, volts_sel[ch]})
             + $signed({{2{item.scale_turns[7]}}, item.scale_turns});
    if (vol_req < 10'sd0) begin
      vol_clamped = 4'd0;
    end else if (vol_req > $signed({6'b0, vol_last})) begin
      vol_clamped = vol_last;
    end else begin
      vol_clamped = vol_req[3:0];
    end
  end

  // Timebase index, clamped the same way.
  always_comb begin
    tb_n = (cfg.timebase_count > TB_MAX_C) ? TB_MAX_C : cfg.timebase_count;
    if (tb_n == 6'd0) begin
      tb_n = 6'd1;
    end
    tb_last = 5'(tb_n - 6'd1);
    tb_req  = $signed({5'b0, timebase_sel})
            + $signed({{2{item.scale_turns[7]}}, item.scale_turns});
    if (tb_req < 10'sd0) begin
      tb_clamped = 5'd0;
    end else if (tb_req > $signed({5'b0, tb_last})) begin
      tb_clamped = tb_last;
    end else begin
      tb_clamped = tb_req[4:0];
    end
  end

  // The active axis decides which settings the shift and scale encoders move.
  always_comb begin
    vertical_next     = vertical_offset[ch];
    horizontal_next   = horizontal_offset[ch];
    volts_next        = volts_sel[ch];
    timebase_sel_next = timebase_sel;
    vol_chg           = 1'b0;
    tb_chg            = 1'b0;
    horiz_chg         = 1'b0;
    if (!axis) begin
      if (shift_move) begin
        vertical_next = shift_sat;
      end
      if (scale_move) begin
        volts_next = vol_clamped;
        vol_chg    = (vol_clamped != volts_sel[ch]);
      end
    end else begin
      if (shift_move) begin
        horizontal_next = shift_sat;
        horiz_chg       = (shift_sat != horizontal_offset[ch]);
      end
      if (scale_move) begin
        timebase_sel_next = tb_clamped;
        tb_chg            = (tb_clamped != timebase_sel);
      end
    end
  end

  // Result of this poll, seen through the new active channel.
  always_comb begin
    result.capture_restart   = chan_chg | trig_chg | tb_chg;
    result.redraw            = chan_chg | axis_chg | trig_chg | tb_chg | vol_chg
                             | horiz_chg | (!axis && shift_move);
    result.current_channel   = ch;
    result.current_axis      = axis;
    result.trigger_level_out = trigger_level_next;
    result.timebase_out      = timebase_sel_next;
    result.volts_index_out   = volts_next;
    result.vertical_out      = vertical_next;
    result.horizontal_out    = horizontal_next;
  end

  // State update when a poll completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_chan          <= 1'b0;
      axis_mode            <= 1'b0;
      trigger_level        <= '0;
      timebase_sel         <= '0;
      volts_sel[0]         <= '0;
      volts_sel[1]         <= '0;
      vertical_offset[0]   <= '0;
      vertical_offset[1]   <= '0;
      horizontal_offset[0] <= '0;
      horizontal_offset[1] <= '0;
    end else if (step) begin
      active_chan           <= ch;
      axis_mode             <= axis;
      trigger_level         <= trigger_level_next;
      timebase_sel          <= timebase_sel_next;
      volts_sel[ch]         <= volts_next;
      vertical_offset[ch]   <= vertical_next;
      horizontal_offset[ch] <= horizontal_next;
    end
  end

  // Checks on the update logic.
  `SPFC_ASSERT(a_recap_implies_redraw, clk, rst,
    step |-> (!result.capture_restart || result.redraw), "capture restart without redraw")
  `SPFC_ASSERT(a_chan_change_recap, clk, rst,
    (step && chan_chg) |-> result.capture_restart, "channel change did not restart capture")
  `SPFC_ASSERT(a_trigger_hold, clk, rst,
    (step && !trig_move) |=> $stable(trigger_level), "trigger level moved with no transition")
  `SPFC_ASSERT(a_timebase_hold, clk, rst,
    (step && !axis) |=> $stable(timebase_sel), "timebase moved on the vertical axis")
  `SPFC_ASSERT_ALWAYS(a_reset_state, clk,
    $past(rst) |-> (trigger_level == 12'd0 && timebase_sel == 5'd0), "state not cleared by reset")

endmodule

`default_nettype wire

// ===== rtl/scope_front_panel_control.sv =====
// Top level of the scope front-panel control block: ports, configuration
// registers, input register and result register. Depends on spfc_pkg, spfc_core.
`timescale 1ns / 1ps
`default_nettype none

// One front-panel poll is accepted per transaction on the in channel and yields
// exactly one result transaction on the out channel. The block takes a new poll
// in every cycle while results are taken: a poll is held in the input register,
// the state update runs in a single pass of short logic, and the result lands
// in the output register, which raises out_valid.
// While a result waits for out_ready the input register takes one more poll
// and then holds in_ready low until the waiting result is taken.
// Configuration writes are always accepted (cfg_ready is tied high); indexes
// past the last register are ignored. Write configuration only while idle.
module scope_front_panel_control
  import spfc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Configuration write channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // Poll channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   channel_switch,
  input  wire logic                   axis_switch,
  input  wire logic signed [7:0]      trig_turns,
  input  wire logic signed [7:0]      shift_turns,
  input  wire logic signed [7:0]      scale_turns,
  // Result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        redraw,
  output logic                        capture_restart,
  output logic                        current_channel,
  output logic                        current_axis,
  output logic [11:0]                 trigger_level_out,
  output logic [4:0]                  timebase_out,
  output logic [3:0]                  volts_index_out,
  output logic signed [15:0]          vertical_out,
  output logic signed [15:0]          horizontal_out
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    step;
  result_t result;
  result_t result_q;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.position_step     <= 8'd1;
      cfg.vertical_step     <= 8'd32;
      cfg.trigger_step      <= 12'd16;
      cfg.adc_max           <= 12'd4095;
      cfg.volts_scale_count <= 5'd16;
      cfg.timebase_count    <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POSITION_STEP:     cfg.position_step     <= cfg_data[7:0];
        CFG_VERTICAL_STEP:     cfg.vertical_step     <= cfg_data[7:0];
        CFG_TRIGGER_STEP:      cfg.trigger_step      <= cfg_data[11:0];
        CFG_ADC_MAX:           cfg.adc_max           <= cfg_data[11:0];
        CFG_VOLTS_SCALE_COUNT: cfg.volts_scale_count <= cfg_data[4:0];
        CFG_TIMEBASE_COUNT:    cfg.timebase_count    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // A held poll moves on once the result register is free or being emptied.
  assign step     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.channel_switch <= channel_switch;
      item.axis_switch    <= axis_switch;
      item.trig_turns     <= trig_turns;
      item.shift_turns    <= shift_turns;
      item.scale_turns    <= scale_turns;
    end
  end

  // State and update logic.
  spfc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .step   (step),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign redraw            = result_q.redraw;
  assign capture_restart   = result_q.capture_restart;
  assign current_channel   = result_q.current_channel;
  assign current_axis      = result_q.current_axis;
  assign trigger_level_out = result_q.trigger_level_out;
  assign timebase_out      = result_q.timebase_out;
  assign volts_index_out   = result_q.volts_index_out;
  assign vertical_out      = result_q.vertical_out;
  assign horizontal_out    = result_q.horizontal_out;

endmodule

`default_nettype wire
